>>> hdl/rmdo_pkg.sv
package rmdo_pkg;

    localparam int SAMPLE_BITS        = 24;
    localparam int PHASE_BITS         = 32;
    localparam int SINE_TABLE_ENTRIES = 256;
    localparam int SINE_INDEX_BITS    = $clog2(SINE_TABLE_ENTRIES);
    localparam int SINE_ENTRY_BITS    = 16;

    localparam int Q15_BITS   = 15;
    localparam int FULL_Q15   = 1 << Q15_BITS;
    localparam int SINE_PEAK  = FULL_Q15 - 1;
    // waveform values span -1.0 .. +1.0 inclusive in Q15
    localparam int WAVE_BITS  = Q15_BITS + 2;

    localparam int STEP_BITS      = 31;
    localparam int SHAPE_BITS     = 2;
    localparam int WET_BITS       = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 31;

    // shared multiplier operand and product widths
    localparam int MUL_A_BITS = SAMPLE_BITS + WAVE_BITS;
    localparam int MUL_B_BITS = WAVE_BITS + 1;
    localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;

    localparam int RING_SHIFT = 2 * Q15_BITS + 1;
    localparam int RING_BITS  = SAMPLE_BITS + 1;
    localparam int ACC_BITS   = SAMPLE_BITS + WAVE_BITS;
    localparam int OUT_SHIFT  = Q15_BITS;
    localparam int RND_BITS   = ACC_BITS - OUT_SHIFT;

    localparam logic [STEP_BITS-1:0] CARRIER_STEP_RESET   = STEP_BITS'(39187271);
    localparam logic [STEP_BITS-1:0] MODULATOR_STEP_RESET = STEP_BITS'(445310);
    localparam logic [WET_BITS-1:0]  WET_RESET            = WET_BITS'(16384);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [SHAPE_BITS-1:0] {
        SHAPE_SINE     = 2'd0,
        SHAPE_TRIANGLE = 2'd1,
        SHAPE_SQUARE   = 2'd2,
        SHAPE_SAW      = 2'd3
    } t_shape;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_CARRIER_STEP    = 3'd0,
        CFG_MODULATOR_STEP  = 3'd1,
        CFG_CARRIER_SHAPE   = 3'd2,
        CFG_MODULATOR_SHAPE = 3'd3,
        CFG_WET_AMOUNT      = 3'd4,
        CFG_BYPASS_ON       = 3'd5
    } t_cfg_index;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WAVE_C,
        S_WAVE_M,
        S_MUL_XC,
        S_MUL_MOD,
        S_MUL_DRY,
        S_MUL_WET,
        S_ACCUM,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [PHASE_BITS-1:0] phase;
        t_shape                shape;
    } t_wave_req;

    typedef logic [SINE_TABLE_ENTRIES-1:0][SINE_ENTRY_BITS-1:0] t_sine_rom;

    // quarter sine entry from a fixed Q30 taylor series, evaluated at elaboration
    function automatic logic [SINE_ENTRY_BITS-1:0] sine_entry(input logic [63:0] idx);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        x    = (HALF_PI_Q30 * idx) / 64'(SINE_TABLE_ENTRIES);
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + signed'(term);
        if (sum <= 64'sd0) begin
            return '0;
        end
        v = ($unsigned(sum) * 64'(SINE_PEAK) + (64'd1 << 29)) >> 30;
        if (v > 64'(SINE_PEAK)) begin
            v = 64'(SINE_PEAK);
        end
        return SINE_ENTRY_BITS'(v);
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        for (int k = 0; k < SINE_TABLE_ENTRIES; k++) begin
            rom[k] = sine_entry(64'(k));
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

>>> hdl/rmdo_if.sv
interface rmdo_in_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [rmdo_pkg::SAMPLE_BITS-1:0]  left_in;
    logic signed [rmdo_pkg::SAMPLE_BITS-1:0]  right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface rmdo_out_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [rmdo_pkg::SAMPLE_BITS-1:0]  left_out;
    logic signed [rmdo_pkg::SAMPLE_BITS-1:0]  right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

interface rmdo_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [rmdo_pkg::CFG_INDEX_BITS-1:0]   index;
    logic [rmdo_pkg::CFG_DATA_BITS-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/rmdo_wave.sv
module rmdo_wave (
    input  rmdo_pkg::t_wave_req                        i_req,
    output logic signed [rmdo_pkg::WAVE_BITS-1:0]      o_value
);

    localparam int PB = rmdo_pkg::PHASE_BITS;
    localparam int QB = PB - 2;
    localparam int IB = rmdo_pkg::SINE_INDEX_BITS;
    localparam int WB = rmdo_pkg::WAVE_BITS;
    localparam int EB = rmdo_pkg::SINE_ENTRY_BITS;

    localparam logic signed [WB+1:0] FULL      = (WB+2)'(rmdo_pkg::FULL_Q15);
    localparam logic signed [WB+1:0] TWO_FULL  = (WB+2)'(2 * rmdo_pkg::FULL_Q15);
    localparam logic signed [WB+1:0] FOUR_FULL = (WB+2)'(4 * rmdo_pkg::FULL_Q15);
    localparam logic [WB-1:0]        TRI_RISE  = WB'(rmdo_pkg::FULL_Q15);
    localparam logic [WB-1:0]        TRI_FALL  = WB'(3 * rmdo_pkg::FULL_Q15);

    logic [PB-1:0]        p;
    logic [1:0]           quad;
    logic [QB:0]          off;
    logic [IB:0]          idx;
    logic [EB-1:0]        sine_mag;
    logic [PB+WB-1:0]     tri_ext;
    logic [WB-1:0]        t;
    logic [PB+WB-2:0]     saw_ext;
    logic [WB-2:0]        s;
    logic signed [WB+1:0] t_s;
    logic signed [WB-1:0] sine_val;
    logic signed [WB-1:0] tri_val;
    logic signed [WB-1:0] sq_val;
    logic signed [WB-1:0] saw_val;

    always_comb begin
        p    = i_req.phase;
        quad = p[PB-1:PB-2];
        // odd quadrants run the table backward
        if (quad[0]) begin
            off = ((QB+1)'(1) << QB) - {1'b0, p[QB-1:0]};
        end else begin
            off = {1'b0, p[QB-1:0]};
        end
        idx = off[QB:QB-IB];
        // the top index bit is set only at the exact quadrant end
        if (idx[IB]) begin
            sine_mag = EB'(rmdo_pkg::SINE_PEAK);
        end else begin
            sine_mag = rmdo_pkg::SINE_ROM[idx[IB-1:0]];
        end
        sine_val = WB'(signed'({1'b0, sine_mag}));
        if (quad[1]) begin
            sine_val = -sine_val;
        end

        tri_ext = {p, WB'(0)};
        t       = tri_ext[PB+WB-1:PB];
        t_s     = signed'({2'b00, t});
        if (t < TRI_RISE) begin
            tri_val = WB'(t_s);
        end else if (t < TRI_FALL) begin
            tri_val = WB'(TWO_FULL - t_s);
        end else begin
            tri_val = WB'(t_s - FOUR_FULL);
        end

        if (p != '0 && !p[PB-1]) begin
            sq_val = WB'(FULL);
        end else begin
            sq_val = WB'(-FULL);
        end

        saw_ext = {p, (WB-1)'(0)};
        s       = saw_ext[PB+WB-2:PB];
        saw_val = signed'({1'b0, s}) - WB'(FULL);

        case (i_req.shape)
            rmdo_pkg::SHAPE_SINE:     o_value = sine_val;
            rmdo_pkg::SHAPE_TRIANGLE: o_value = tri_val;
            rmdo_pkg::SHAPE_SQUARE:   o_value = sq_val;
            default:                  o_value = saw_val;
        endcase
    end

endmodule

>>> hdl/rmdo_mul.sv
module rmdo_mul (
    input  logic                                       i_clk,
    input  logic signed [rmdo_pkg::MUL_A_BITS-1:0]     i_a,
    input  logic signed [rmdo_pkg::MUL_B_BITS-1:0]     i_b,
    output logic signed [rmdo_pkg::MUL_P_BITS-1:0]     o_prod
);

    logic signed [rmdo_pkg::MUL_P_BITS-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= rmdo_pkg::MUL_P_BITS'(i_a) * rmdo_pkg::MUL_P_BITS'(i_b);
    end

    assign o_prod = r_prod;

endmodule

>>> hdl/ring_modulator_dual_oscillator.sv
// a frame is accepted only in idle, so the next frame waits until the last result has left done
// processing runs the shared waveform unit once per oscillator (carrier, then modulator), then one
// shared multiplier taking four products and an accumulate step per channel; a bypassed frame goes
// straight to done, and done waits while the output slot is still full
// reset (synchronous, active low): phases to zero, registers to defaults, output empty;
// the quarter sine table is a constant rom
module ring_modulator_dual_oscillator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rmdo_in_if.sink     i_in,
    rmdo_out_if.source  o_out,
    rmdo_cfg_if.sink    i_cfg
);

    localparam int SB  = rmdo_pkg::SAMPLE_BITS;
    localparam int PB  = rmdo_pkg::PHASE_BITS;
    localparam int WB  = rmdo_pkg::WAVE_BITS;
    localparam int AB  = rmdo_pkg::MUL_A_BITS;
    localparam int BB  = rmdo_pkg::MUL_B_BITS;
    localparam int PRB = rmdo_pkg::MUL_P_BITS;
    localparam int RB  = rmdo_pkg::RING_BITS;
    localparam int CB  = rmdo_pkg::ACC_BITS;
    localparam int NB  = rmdo_pkg::RND_BITS;
    localparam int RS  = rmdo_pkg::RING_SHIFT;
    localparam int OS  = rmdo_pkg::OUT_SHIFT;
    localparam int TB  = rmdo_pkg::STEP_BITS;
    localparam int XB  = rmdo_pkg::WET_BITS;

    localparam logic [XB-1:0]        W_FULL = XB'(rmdo_pkg::FULL_Q15);
    localparam logic signed [NB-1:0] SAT_HI = NB'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [NB-1:0] SAT_LO = -SAT_HI - NB'(1);

    // configuration
    logic [TB-1:0]     r_car_step;
    logic [TB-1:0]     r_mod_step;
    rmdo_pkg::t_shape  r_car_shape;
    rmdo_pkg::t_shape  r_mod_shape;
    logic [XB-1:0]     r_wet;
    logic              r_bypass;

    // control
    rmdo_pkg::t_state  r_state;
    rmdo_pkg::t_state  n_state;
    logic              r_ch;
    logic              r_out_valid;
    logic [PB-1:0]     r_car_phase;
    logic [PB-1:0]     r_mod_phase;

    // datapath
    logic signed [SB-1:0] r_left;
    logic signed [SB-1:0] r_right;
    logic signed [WB-1:0] r_c;
    logic signed [BB-1:0] r_mp;
    logic signed [RB-1:0] r_ring;
    logic signed [CB-1:0] r_acc;
    logic signed [SB-1:0] r_res_l;
    logic signed [SB-1:0] r_res_r;
    logic signed [SB-1:0] r_out_l;
    logic signed [SB-1:0] r_out_r;

    logic                  in_xfer;
    logic                  out_free;
    logic [XB-1:0]         w_eff;
    logic [XB-1:0]         w_dry;
    logic signed [SB-1:0]  x_sel;
    rmdo_pkg::t_wave_req   wave_req;
    logic signed [WB-1:0]  wave_value;
    logic signed [AB-1:0]  mul_a;
    logic signed [BB-1:0]  mul_b;
    logic signed [PRB-1:0] mul_prod;
    logic signed [PRB-1:0] ring_sum;
    logic signed [RB-1:0]  ring_val;
    logic signed [CB-1:0]  acc_sum;
    logic signed [NB-1:0]  rnd;
    logic signed [SB-1:0]  sat;

    rmdo_wave u_wave (
        .i_req   (wave_req),
        .o_value (wave_value)
    );

    rmdo_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    assign in_xfer     = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == rmdo_pkg::S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid     = r_out_valid;
    assign o_out.left_out  = r_out_l;
    assign o_out.right_out = r_out_r;

    assign w_eff = (r_wet > W_FULL) ? W_FULL : r_wet;
    assign w_dry = W_FULL - w_eff;
    assign x_sel = r_ch ? r_right : r_left;

    // rounding of the ring product and of the blended sum, half up
    assign ring_sum = mul_prod + (PRB'(1) <<< (RS - 1));
    assign ring_val = signed'(ring_sum[RS+RB-1:RS]);
    assign acc_sum  = r_acc + mul_prod[CB-1:0] + (CB'(1) <<< (OS - 1));
    assign rnd      = signed'(acc_sum[CB-1:OS]);

    always_comb begin
        if (rnd > SAT_HI) begin
            sat = SB'(SAT_HI);
        end else if (rnd < SAT_LO) begin
            sat = SB'(SAT_LO);
        end else begin
            sat = SB'(rnd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_car_step  <= rmdo_pkg::CARRIER_STEP_RESET;
            r_mod_step  <= rmdo_pkg::MODULATOR_STEP_RESET;
            r_car_shape <= rmdo_pkg::SHAPE_SINE;
            r_mod_shape <= rmdo_pkg::SHAPE_SINE;
            r_wet       <= rmdo_pkg::WET_RESET;
            r_bypass    <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                rmdo_pkg::CFG_CARRIER_STEP:    r_car_step  <= i_cfg.data[TB-1:0];
                rmdo_pkg::CFG_MODULATOR_STEP:  r_mod_step  <= i_cfg.data[TB-1:0];
                rmdo_pkg::CFG_CARRIER_SHAPE:
                    r_car_shape <= rmdo_pkg::t_shape'(i_cfg.data[rmdo_pkg::SHAPE_BITS-1:0]);
                rmdo_pkg::CFG_MODULATOR_SHAPE:
                    r_mod_shape <= rmdo_pkg::t_shape'(i_cfg.data[rmdo_pkg::SHAPE_BITS-1:0]);
                rmdo_pkg::CFG_WET_AMOUNT:      r_wet       <= i_cfg.data[XB-1:0];
                rmdo_pkg::CFG_BYPASS_ON:       r_bypass    <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state        = r_state;
        wave_req.phase = r_mod_phase;
        wave_req.shape = r_mod_shape;
        mul_a          = '0;
        mul_b          = '0;
        case (r_state)
            rmdo_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_state = r_bypass ? rmdo_pkg::S_DONE : rmdo_pkg::S_WAVE_C;
                end
            end
            rmdo_pkg::S_WAVE_C: begin
                wave_req.phase = r_car_phase;
                wave_req.shape = r_car_shape;
                n_state        = rmdo_pkg::S_WAVE_M;
            end
            rmdo_pkg::S_WAVE_M: begin
                n_state = rmdo_pkg::S_MUL_XC;
            end
            rmdo_pkg::S_MUL_XC: begin
                mul_a   = AB'(x_sel);
                mul_b   = BB'(r_c);
                n_state = rmdo_pkg::S_MUL_MOD;
            end
            rmdo_pkg::S_MUL_MOD: begin
                mul_a   = mul_prod[AB-1:0];
                mul_b   = r_mp;
                n_state = rmdo_pkg::S_MUL_DRY;
            end
            rmdo_pkg::S_MUL_DRY: begin
                mul_a   = AB'(x_sel);
                mul_b   = BB'(signed'({1'b0, w_dry}));
                n_state = rmdo_pkg::S_MUL_WET;
            end
            rmdo_pkg::S_MUL_WET: begin
                mul_a   = AB'(r_ring);
                mul_b   = BB'(signed'({1'b0, w_eff}));
                n_state = rmdo_pkg::S_ACCUM;
            end
            rmdo_pkg::S_ACCUM: begin
                n_state = r_ch ? rmdo_pkg::S_DONE : rmdo_pkg::S_MUL_XC;
            end
            rmdo_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = rmdo_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rmdo_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rmdo_pkg::S_IDLE;
            r_ch        <= 1'b0;
            r_out_valid <= 1'b0;
            r_car_phase <= '0;
            r_mod_phase <= '0;
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                r_ch <= 1'b0;
            end else if (r_state == rmdo_pkg::S_ACCUM) begin
                r_ch <= ~r_ch;
            end
            // phases move once per processed frame
            if (r_state == rmdo_pkg::S_ACCUM && r_ch) begin
                r_car_phase <= r_car_phase + PB'(r_car_step);
                r_mod_phase <= r_mod_phase + PB'(r_mod_step);
            end
            if (r_state == rmdo_pkg::S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            rmdo_pkg::S_IDLE: begin
                if (in_xfer) begin
                    r_left  <= i_in.left_in;
                    r_right <= i_in.right_in;
                    // bypass result, overwritten when processing
                    r_res_l <= i_in.left_in;
                    r_res_r <= i_in.right_in;
                end
            end
            rmdo_pkg::S_WAVE_C: r_c <= wave_value;
            rmdo_pkg::S_WAVE_M: r_mp <= BB'(wave_value) + BB'(rmdo_pkg::FULL_Q15);
            rmdo_pkg::S_MUL_DRY: r_ring <= ring_val;
            rmdo_pkg::S_MUL_WET: r_acc <= mul_prod[CB-1:0];
            rmdo_pkg::S_ACCUM: begin
                if (r_ch) begin
                    r_res_r <= sat;
                end else begin
                    r_res_l <= sat;
                end
            end
            rmdo_pkg::S_DONE: begin
                if (out_free) begin
                    r_out_l <= r_res_l;
                    r_out_r <= r_res_r;
                end
            end
            default: begin
            end
        endcase
    end

    a_rise_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == rmdo_pkg::S_DONE)
        else $error("output became valid outside the done state");

    a_accept_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !r_bypass) |=> r_state == rmdo_pkg::S_WAVE_C)
        else $error("processed frame did not start with the carrier wave");

    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rmdo_pkg::S_DONE && r_out_valid && !o_out.ready)
        |=> r_state == rmdo_pkg::S_DONE)
        else $error("done state left while the output slot was full");

    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !($past(r_state) == rmdo_pkg::S_ACCUM && $past(r_ch)))
        |-> ($stable(r_car_phase) && $stable(r_mod_phase)))
        else $error("phase moved outside the end of a processed frame");

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CLK_HALF_NS      = 10;
    localparam int TIMEOUT_NS       = 12_000_000;
    localparam int ITEM_TARGET      = 1250;
    localparam int DRAIN_CYCLES     = 16;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int HOLD_PHASE       = 2;

    localparam int SAMPLE_MAX  = (1 << (rmdo_pkg::SAMPLE_BITS - 1)) - 1;
    localparam int SAMPLE_MIN  = -SAMPLE_MAX - 1;
    localparam int TABLE_SHIFT = rmdo_pkg::PHASE_BITS - 2
                                 - $clog2(rmdo_pkg::SINE_TABLE_ENTRIES);

    localparam logic [63:0] HALF_PI_FRAC = 64'd1686629713;
    localparam logic [rmdo_pkg::PHASE_BITS-2:0] QUARTER_TURN = 1 << (rmdo_pkg::PHASE_BITS - 2);
    localparam logic [rmdo_pkg::STEP_BITS-1:0]  STEP_MAX     = '1;
    localparam logic [rmdo_pkg::WET_BITS-1:0]   WET_FULL     =
        rmdo_pkg::WET_BITS'(rmdo_pkg::FULL_Q15);

    // indexes outside the register map, writes there must be ignored
    localparam logic [rmdo_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [rmdo_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 3'd7;

    typedef logic signed [rmdo_pkg::SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        t_sample left;
        t_sample right;
    } t_stereo;

    class ring_mod_tracker;
        int                              quarter_sine [rmdo_pkg::SINE_TABLE_ENTRIES];
        logic [rmdo_pkg::STEP_BITS-1:0]  carrier_step;
        logic [rmdo_pkg::STEP_BITS-1:0]  modulator_step;
        rmdo_pkg::t_shape                carrier_shape;
        rmdo_pkg::t_shape                modulator_shape;
        logic [rmdo_pkg::WET_BITS-1:0]   wet_amount;
        logic                            bypass_on;
        logic [rmdo_pkg::PHASE_BITS-1:0] carrier_phase;
        logic [rmdo_pkg::PHASE_BITS-1:0] modulator_phase;
        t_stereo                         awaited [$];
        int                              errors;
        int                              compared;
        int                              bypassed;
        int                              clipped;

        function new();
            for (int i = 0; i < rmdo_pkg::SINE_TABLE_ENTRIES; i++) begin
                quarter_sine[i] = taylor_sine(i);
            end
            carrier_step    = 31'd39187271;
            modulator_step  = 31'd445310;
            carrier_shape   = rmdo_pkg::SHAPE_SINE;
            modulator_shape = rmdo_pkg::SHAPE_SINE;
            wet_amount      = 16'd16384;
            bypass_on       = 1'b0;
            carrier_phase   = '0;
            modulator_phase = '0;
            errors          = 0;
            compared        = 0;
            bypassed        = 0;
            clipped         = 0;
        endfunction

        // q30 series up to the x^13 term, scaled to 32767 and clamped
        function int taylor_sine(int i);
            longint unsigned x;
            longint unsigned x2;
            longint unsigned term;
            longint unsigned v;
            longint          sum;
            x    = (HALF_PI_FRAC * longint'(i)) / rmdo_pkg::SINE_TABLE_ENTRIES;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 6; k++) begin
                term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum <= 0) begin
                return 0;
            end
            v = (longint'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            return int'(v);
        endfunction

        function int osc_value(logic [rmdo_pkg::PHASE_BITS-1:0] p, rmdo_pkg::t_shape s);
            logic [1:0]                      quad;
            logic [rmdo_pkg::PHASE_BITS-2:0] offset;
            int                              idx;
            int                              mag;
            int                              t;
            case (s)
                rmdo_pkg::SHAPE_SINE: begin
                    quad   = p[rmdo_pkg::PHASE_BITS-1 -: 2];
                    offset = quad[0] ? QUARTER_TURN - p[rmdo_pkg::PHASE_BITS-3:0]
                                     : p[rmdo_pkg::PHASE_BITS-3:0];
                    idx    = int'(offset >> TABLE_SHIFT);
                    // mirrored offset of a full quarter lands past the table
                    mag    = (idx >= rmdo_pkg::SINE_TABLE_ENTRIES) ? rmdo_pkg::SINE_PEAK
                                                                   : quarter_sine[idx];
                    return quad[1] ? -mag : mag;
                end
                rmdo_pkg::SHAPE_TRIANGLE: begin
                    t = int'(p >> (rmdo_pkg::PHASE_BITS - 17));
                    if (t < 32768) begin
                        return t;
                    end
                    if (t < 98304) begin
                        return 65536 - t;
                    end
                    return t - 131072;
                end
                rmdo_pkg::SHAPE_SQUARE: begin
                    return (p != 0 && !p[rmdo_pkg::PHASE_BITS-1]) ? rmdo_pkg::FULL_Q15
                                                                  : -rmdo_pkg::FULL_Q15;
                end
                default: begin
                    return int'(p >> (rmdo_pkg::PHASE_BITS - 16)) - rmdo_pkg::FULL_Q15;
                end
            endcase
        endfunction

        // round half up
        function longint round_off(longint v, int s);
            return (v + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        function t_sample blend_sample(longint x, longint c, longint m, longint w);
            longint ring;
            longint acc;
            longint y;
            ring = round_off(x * c * (rmdo_pkg::FULL_Q15 + m), 2 * rmdo_pkg::Q15_BITS + 1);
            acc  = (rmdo_pkg::FULL_Q15 - w) * x + w * ring;
            y    = round_off(acc, rmdo_pkg::Q15_BITS);
            if (y > SAMPLE_MAX) begin
                y = SAMPLE_MAX;
                clipped++;
            end else if (y < SAMPLE_MIN) begin
                y = SAMPLE_MIN;
                clipped++;
            end
            return t_sample'(y);
        endfunction

        function void set_register(logic [rmdo_pkg::CFG_INDEX_BITS-1:0] idx,
                                   logic [rmdo_pkg::CFG_DATA_BITS-1:0] d);
            case (idx)
                rmdo_pkg::CFG_CARRIER_STEP:    carrier_step   = d[rmdo_pkg::STEP_BITS-1:0];
                rmdo_pkg::CFG_MODULATOR_STEP:  modulator_step = d[rmdo_pkg::STEP_BITS-1:0];
                rmdo_pkg::CFG_CARRIER_SHAPE:
                    carrier_shape = rmdo_pkg::t_shape'(d[rmdo_pkg::SHAPE_BITS-1:0]);
                rmdo_pkg::CFG_MODULATOR_SHAPE:
                    modulator_shape = rmdo_pkg::t_shape'(d[rmdo_pkg::SHAPE_BITS-1:0]);
                rmdo_pkg::CFG_WET_AMOUNT:      wet_amount     = d[rmdo_pkg::WET_BITS-1:0];
                rmdo_pkg::CFG_BYPASS_ON:       bypass_on      = d[0];
                default: ;
            endcase
        endfunction

        function void accept_frame(t_sample l, t_sample r);
            t_stereo f;
            int      c;
            int      m;
            longint  w;
            if (bypass_on) begin
                f.left  = l;
                f.right = r;
                bypassed++;
            end else begin
                c = osc_value(carrier_phase, carrier_shape);
                m = osc_value(modulator_phase, modulator_shape);
                w = (wet_amount > WET_FULL) ? rmdo_pkg::FULL_Q15 : longint'(wet_amount);
                f.left          = blend_sample(l, c, m, w);
                f.right         = blend_sample(r, c, m, w);
                carrier_phase   = carrier_phase + carrier_step;
                modulator_phase = modulator_phase + modulator_step;
            end
            awaited = {awaited, f};
        endfunction

        function void compare_frame(t_sample l, t_sample r);
            t_stereo want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: output frame with nothing awaited, left %0d right %0d",
                         $time, l, r);
                return;
            end
            want = awaited.pop_front();
            compared++;
            if (l !== want.left) begin
                errors++;
                $display("%0t: left_out expected %0d got %0d", $time, want.left, l);
            end
            if (r !== want.right) begin
                errors++;
                $display("%0t: right_out expected %0d got %0d", $time, want.right, r);
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    rmdo_in_if  in_ch ();
    rmdo_out_if out_ch ();
    rmdo_cfg_if cfg_ch ();

    ring_modulator_dual_oscillator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    ring_mod_tracker tracker;
    int  frames_sent    = 0;
    int  settings_count = 0;
    int  sink_stall_pct = 0;
    bit  hold_start     = 1'b0;
    bit  long_hold      = 1'b0;
    t_sample corner [4] = '{t_sample'(SAMPLE_MAX), t_sample'(SAMPLE_MIN), '0, '1};

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    initial begin
        #TIMEOUT_NS;
        $display("tb: errors");
        $finish;
    end

    function int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 6) begin
            return $urandom_range(40, 10);
        end
        if (r < 30) begin
            return $urandom_range(3, 1);
        end
        return 0;
    endfunction

    function t_sample pick_sample();
        int r;
        r = $urandom_range(9);
        case (r)
            0: return t_sample'(SAMPLE_MAX);
            1: return t_sample'(SAMPLE_MIN);
            2: return t_sample'(int'($urandom_range(1023)) - 512);
            default: return t_sample'($urandom);
        endcase
    endfunction

    function logic [rmdo_pkg::STEP_BITS-1:0] pick_step();
        int r;
        r = $urandom_range(9);
        case (r)
            0: return '0;
            1: return STEP_MAX;
            2, 3, 4: return rmdo_pkg::STEP_BITS'($urandom_range(1 << 20));
            default: return rmdo_pkg::STEP_BITS'($urandom);
        endcase
    endfunction

    function logic [rmdo_pkg::WET_BITS-1:0] pick_wet();
        int r;
        r = $urandom_range(9);
        case (r)
            0: return '0;
            1: return WET_FULL;
            2: return rmdo_pkg::WET_BITS'($urandom_range(65535, rmdo_pkg::FULL_Q15 + 1));
            default: return rmdo_pkg::WET_BITS'($urandom_range(rmdo_pkg::FULL_Q15));
        endcase
    endfunction

    // receiver: random stalls, plus one long hold to back up the input
    initial begin
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if (sink_stall_pct > 0 && $urandom_range(99) < sink_stall_pct) begin
                    stall_left = ($urandom_range(9) == 0) ? $urandom_range(40, 10)
                                                          : $urandom_range(3, 1);
                end
            end
        end
    end

    initial begin
        wait (hold_start);
        @(posedge i_clk);
        long_hold = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
        long_hold = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            tracker.compare_frame(out_ch.left_out, out_ch.right_out);
        end
    end

    // leaves valid high so that back-to-back frames need no extra edge
    task automatic send_frame(t_sample l, t_sample r, int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid    <= 1'b1;
        in_ch.left_in  <= l;
        in_ch.right_in <= r;
        do @(posedge i_clk); while (!in_ch.ready);
        tracker.accept_frame(l, r);
        frames_sent++;
    endtask

    task automatic write_reg(logic [rmdo_pkg::CFG_INDEX_BITS-1:0] idx,
                             logic [rmdo_pkg::CFG_DATA_BITS-1:0] d);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        tracker.set_register(idx, d);
    endtask

    // scramble fills the unused upper data bits and pokes a spare index
    task automatic apply_settings(logic [rmdo_pkg::STEP_BITS-1:0] c_step,
                                  logic [rmdo_pkg::STEP_BITS-1:0] m_step,
                                  rmdo_pkg::t_shape c_shape, rmdo_pkg::t_shape m_shape,
                                  logic [rmdo_pkg::WET_BITS-1:0] wet, logic byp,
                                  bit scramble);
        logic [rmdo_pkg::CFG_DATA_BITS-1:0] d;
        if (scramble) begin
            write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                      rmdo_pkg::CFG_DATA_BITS'($urandom));
        end
        write_reg(rmdo_pkg::CFG_CARRIER_STEP, rmdo_pkg::CFG_DATA_BITS'(c_step));
        write_reg(rmdo_pkg::CFG_MODULATOR_STEP, rmdo_pkg::CFG_DATA_BITS'(m_step));
        d = scramble ? rmdo_pkg::CFG_DATA_BITS'($urandom) : '0;
        d[rmdo_pkg::SHAPE_BITS-1:0] = c_shape;
        write_reg(rmdo_pkg::CFG_CARRIER_SHAPE, d);
        d = scramble ? rmdo_pkg::CFG_DATA_BITS'($urandom) : '0;
        d[rmdo_pkg::SHAPE_BITS-1:0] = m_shape;
        write_reg(rmdo_pkg::CFG_MODULATOR_SHAPE, d);
        d = scramble ? rmdo_pkg::CFG_DATA_BITS'($urandom) : '0;
        d[rmdo_pkg::WET_BITS-1:0] = wet;
        write_reg(rmdo_pkg::CFG_WET_AMOUNT, d);
        d = scramble ? rmdo_pkg::CFG_DATA_BITS'($urandom) : '0;
        d[0] = byp;
        write_reg(rmdo_pkg::CFG_BYPASS_ON, d);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        settings_count++;
    endtask

    // wait for every awaited frame, then let the pipeline empty
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        logic [rmdo_pkg::STEP_BITS-1:0] c_step;
        logic [rmdo_pkg::STEP_BITS-1:0] m_step;
        rmdo_pkg::t_shape               c_shape;
        rmdo_pkg::t_shape               m_shape;
        logic [rmdo_pkg::WET_BITS-1:0]  wet;
        logic                           byp;
        int                             count;
        int                             phase_no;
        bit                             calm;

        tracker        = new();
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.left_in  = '0;
        in_ch.right_in = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = '0;
        cfg_ch.data    = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: phases start from zero, so quarter steps land on the quadrant
        // boundaries (sine peak past the table, square at exactly zero), then a
        // negative full-scale input against c = -1, m = +1 overflows
        sink_stall_pct = 20;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: apply_settings(31'h4000_0000, 31'h1000_0000, rmdo_pkg::SHAPE_SINE,
                                  rmdo_pkg::SHAPE_SQUARE, WET_FULL, 1'b0, 1'b0);
                1: apply_settings(31'h4000_0000, '0, rmdo_pkg::SHAPE_SQUARE,
                                  rmdo_pkg::SHAPE_SQUARE, 16'hFFFF, 1'b0, 1'b0);
                2: apply_settings(STEP_MAX, 31'd1, rmdo_pkg::SHAPE_TRIANGLE,
                                  rmdo_pkg::SHAPE_SAW, '0, 1'b0, 1'b0);
                3: apply_settings(31'h1234_5678, STEP_MAX, rmdo_pkg::SHAPE_SAW,
                                  rmdo_pkg::SHAPE_TRIANGLE, 16'd12345, 1'b0, 1'b1);
                default: apply_settings('0, '0, rmdo_pkg::SHAPE_SINE, rmdo_pkg::SHAPE_SQUARE,
                                        WET_FULL, 1'b1, 1'b1);
            endcase
            for (int k = 0; k < 4; k++) begin
                send_frame(corner[(k + ph) % 4], corner[(k + ph + 2) % 4], pick_gap());
            end
            settle();
        end

        phase_no = 0;
        while (frames_sent < ITEM_TARGET) begin
            c_step  = pick_step();
            m_step  = pick_step();
            c_shape = rmdo_pkg::t_shape'($urandom_range(3));
            m_shape = rmdo_pkg::t_shape'($urandom_range(3));
            wet     = pick_wet();
            byp     = ($urandom_range(7) == 0);
            apply_settings(c_step, m_step, c_shape, m_shape, wet, byp,
                           1'($urandom_range(1)));
            calm           = ($urandom_range(3) == 0);
            sink_stall_pct = calm ? 0 : $urandom_range(40, 5);
            count          = $urandom_range(120, 20);
            if (phase_no == HOLD_PHASE) begin
                count      = 80;
                calm       = 1'b1;
                hold_start = 1'b1;
            end
            if (count > ITEM_TARGET - frames_sent) begin
                count = ITEM_TARGET - frames_sent;
            end
            for (int k = 0; k < count; k++) begin
                send_frame(pick_sample(), pick_sample(), calm ? 0 : pick_gap());
            end
            settle();
            phase_no++;
        end

        $display("summary: %0d stereo frames compared over %0d register settings",
                 tracker.compared, settings_count);
        $display("summary: %0d bypassed, %0d samples clipped, one %0d-cycle output hold",
                 tracker.bypassed, tracker.clipped, LONG_HOLD_CYCLES);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/rmdo_pkg.sv
hdl/rmdo_if.sv
hdl/rmdo_wave.sv
hdl/rmdo_mul.sv
hdl/ring_modulator_dual_oscillator.sv
dv/tb.sv
